// File: design/lgse_pkg.sv
// Package for the lane grid softmax expectation block.
// Holds the controller/datapath command and status types, the state enum and
// the exp table generator. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package lgse_pkg;

  localparam int LOGIT_W   = 16;
  localparam int BIN_W     = 7;
  localparam int LOC_W     = 15;
  localparam int EXP_W     = 17;
  localparam int ESUM_W    = 24;
  localparam int WSUM_W    = 32;
  localparam int NUM_W     = WSUM_W + 8;
  localparam int DIVCNT_W  = 6;
  localparam logic [BIN_W-1:0] NUM_BINS_RESET = 7'd100;
  localparam logic [63:0] EXP_STEP_RATIO = 64'd4034748382;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_WALK,
    ST_DRAIN,
    ST_DIV_INIT,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load_bin;
    logic finish;
    logic walk_issue;
    logic div_start;
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic is_final;
    logic no_bins;
    logic rd_last;
    logic pipe_busy;
    logic div_last;
    logic out_busy;
  } status_t;

  // exp(-k/16) in Q1.16 from the Q32 recurrence; evaluated at elaboration.
  function automatic logic [EXP_W-1:0] exp_entry(input int k);
    logic [64:0] v;
    logic [64:0] p;
    begin
      v = 65'd1 << 32;
      for (int i = 0; i < k; i++) begin
        p = v * {1'b0, EXP_STEP_RATIO};
        p = p + (65'd1 << 31);
        v = p >> 32;
      end
      p = (v + 65'd32768) >> 16;
      exp_entry = p[EXP_W-1:0];
    end
  endfunction

endpackage
`default_nettype wire

// File: design/lgse_ctrl.sv
// Controller state machine for the lane grid softmax expectation block.
// Depends on lgse_pkg; drives the datapath through cmd_t, reads status_t.
`timescale 1ns / 1ps
`default_nettype none
module lgse_ctrl (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_ready,
  input  lgse_pkg::status_t  sts,
  output lgse_pkg::cmd_t     cmd
);

  lgse_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lgse_pkg::ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lgse_pkg::ST_LOAD: begin
        if (in_valid && sts.is_final) begin
          state_nxt = sts.no_bins ? lgse_pkg::ST_DIV_INIT : lgse_pkg::ST_WALK;
        end
      end
      lgse_pkg::ST_WALK: begin
        if (sts.rd_last) state_nxt = lgse_pkg::ST_DRAIN;
      end
      lgse_pkg::ST_DRAIN: begin
        if (!sts.pipe_busy) state_nxt = lgse_pkg::ST_DIV_INIT;
      end
      lgse_pkg::ST_DIV_INIT: state_nxt = lgse_pkg::ST_DIV;
      lgse_pkg::ST_DIV: begin
        if (sts.div_last) state_nxt = lgse_pkg::ST_OUT;
      end
      lgse_pkg::ST_OUT: begin
        if (!sts.out_busy) state_nxt = lgse_pkg::ST_LOAD;
      end
      default: state_nxt = lgse_pkg::ST_LOAD;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      lgse_pkg::ST_LOAD: begin
        in_ready       = 1'b1;
        cmd.load_bin   = in_valid && !sts.is_final;
        cmd.finish     = in_valid && sts.is_final;
      end
      lgse_pkg::ST_WALK:     cmd.walk_issue = 1'b1;
      lgse_pkg::ST_DIV_INIT: cmd.div_start  = 1'b1;
      lgse_pkg::ST_DIV:      cmd.div_step   = 1'b1;
      lgse_pkg::ST_OUT:      cmd.out_load   = !sts.out_busy;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// File: design/lgse_dp.sv
// Datapath: logit store, running max, exp walk pipeline, divider, result register.
// Depends on lgse_pkg; commanded by lgse_ctrl.
`timescale 1ns / 1ps
`default_nettype none
module lgse_dp #(
  parameter int MAX_CHANNELS    = 128,
  parameter int EXP_TABLE_DEPTH = 256
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire signed [lgse_pkg::LOGIT_W-1:0] in_logit,
  input  wire                               cfg_wr,
  input  wire        [lgse_pkg::BIN_W-1:0]  cfg_num_bins,
  input  lgse_pkg::cmd_t                    cmd,
  output lgse_pkg::status_t                 sts,
  output logic                              out_valid,
  input  wire                               out_ready,
  output logic       [lgse_pkg::LOC_W-1:0]  out_location,
  output logic       [lgse_pkg::BIN_W-1:0]  out_best_bin,
  output logic                              out_lane_present
);

  localparam int AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int IW = $clog2(EXP_TABLE_DEPTH);
  localparam int KW = 13;
  localparam int BW = lgse_pkg::BIN_W;
  localparam int LW = lgse_pkg::LOGIT_W;
  localparam int EW = lgse_pkg::EXP_W;
  localparam int NW = lgse_pkg::NUM_W;
  localparam int SW = lgse_pkg::ESUM_W;
  localparam logic [AW-1:0] ADDR_LAST = AW'(MAX_CHANNELS - 1);

  // exp table, built at elaboration
  logic [EW-1:0] exp_rom [EXP_TABLE_DEPTH];
  for (genvar g = 0; g < EXP_TABLE_DEPTH; g++) begin : g_rom
    assign exp_rom[g] = lgse_pkg::exp_entry(g);
  end

  logic [BW-1:0]        num_bins_r;
  logic [BW-1:0]        cnt_r;
  logic [AW-1:0]        wr_addr_r;
  logic signed [LW-1:0] max_r, wmax_r;
  logic [BW-1:0]        max_ch_r, best_r;
  logic [LW-1:0]        mem [MAX_CHANNELS];
  logic [LW-1:0]        rd_data_r;
  logic [AW-1:0]        rd_addr_r;
  logic [BW-1:0]        rd_cnt_r, c1_r, c2_r;
  logic                 v1_r, v2_r;
  logic [EW-1:0]        e2_r;
  logic [SW-1:0]        esum_r;
  logic [lgse_pkg::WSUM_W-1:0] wsum_r;
  logic [NW-1:0]        num_r;
  logic [SW:0]          rem_r;
  logic [lgse_pkg::DIVCNT_W-1:0] div_cnt_r;

  // cell load and running max
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_bins_r <= lgse_pkg::NUM_BINS_RESET;
      cnt_r      <= '0;
      wr_addr_r  <= '0;
      max_r      <= {1'b1, {(LW-1){1'b0}}};
      max_ch_r   <= '0;
    end else if (cfg_wr || cmd.finish) begin
      if (cfg_wr) num_bins_r <= cfg_num_bins;
      cnt_r     <= '0;
      wr_addr_r <= '0;
      max_r     <= {1'b1, {(LW-1){1'b0}}};
      max_ch_r  <= '0;
    end else if (cmd.load_bin) begin
      cnt_r     <= cnt_r + 1'b1;
      wr_addr_r <= (wr_addr_r == ADDR_LAST) ? '0 : wr_addr_r + 1'b1;
      if (in_logit > max_r) begin
        max_r    <= in_logit;
        max_ch_r <= cnt_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_bin) mem[wr_addr_r] <= in_logit;
    if (cmd.walk_issue) rd_data_r <= mem[rd_addr_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      wmax_r <= max_r;
      best_r <= (in_logit > max_r) ? num_bins_r : max_ch_r;
    end
  end

  // walk pipeline: read, exp lookup, accumulate
  logic [LW:0]   diff;
  logic [KW-1:0] kidx;
  logic [EW-1:0] e_val;
  logic [BW+EW-1:0] prod;

  always_comb begin
    diff  = {wmax_r[LW-1], wmax_r} - {rd_data_r[LW-1], rd_data_r};
    kidx  = KW'(({1'b0, diff[LW-1:0]} + 17'd8) >> 4);
    e_val = (kidx < KW'(EXP_TABLE_DEPTH)) ? exp_rom[kidx[IW-1:0]] : '0;
    prod  = c2_r * e2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= cmd.walk_issue;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      rd_cnt_r  <= '0;
      rd_addr_r <= '0;
      esum_r    <= '0;
      wsum_r    <= '0;
    end else begin
      if (cmd.walk_issue) begin
        rd_cnt_r  <= rd_cnt_r + 1'b1;
        rd_addr_r <= (rd_addr_r == ADDR_LAST) ? '0 : rd_addr_r + 1'b1;
      end
      if (v2_r) begin
        esum_r <= esum_r + SW'(e2_r);
        wsum_r <= wsum_r + lgse_pkg::WSUM_W'(prod);
      end
    end
    c1_r <= rd_cnt_r;
    c2_r <= c1_r;
    e2_r <= e_val;
  end

  // restoring divider, one quotient bit per cycle
  logic [SW:0] rem_sh;
  logic        fits;
  always_comb begin
    rem_sh = {rem_r[SW-1:0], num_r[NW-1]};
    fits   = rem_sh >= {1'b0, esum_r};
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      num_r     <= {wsum_r, 8'd0} + NW'(esum_r >> 1);
      rem_r     <= '0;
      div_cnt_r <= lgse_pkg::DIVCNT_W'(NW);
    end else if (cmd.div_step) begin
      rem_r     <= fits ? rem_sh - {1'b0, esum_r} : rem_sh;
      num_r     <= {num_r[NW-2:0], fits};
      div_cnt_r <= div_cnt_r - 1'b1;
    end
  end

  // result register
  logic                present;
  logic [BW+8-1:0]     loc_full;
  logic [lgse_pkg::LOC_W-1:0] loc;
  always_comb begin
    present  = (best_r != num_bins_r) && (esum_r != '0);
    loc      = (num_r[NW-1:lgse_pkg::LOC_W] != '0) ? '1 : num_r[lgse_pkg::LOC_W-1:0];
    if (!present) loc = '0;
    loc_full = (BW+8)'(loc);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_location     <= loc;
      out_best_bin     <= best_r;
      out_lane_present <= present && (loc_full > (BW+8)'(256));
    end
  end

  always_comb begin
    sts.is_final  = (cnt_r == num_bins_r);
    sts.no_bins   = (num_bins_r == '0);
    sts.rd_last   = (rd_cnt_r == num_bins_r - 1'b1);
    sts.pipe_busy = v1_r || v2_r;
    sts.div_last  = (div_cnt_r == lgse_pkg::DIVCNT_W'(1));
    sts.out_busy  = out_valid && !out_ready;
  end

endmodule
`default_nettype wire

// File: design/lane_grid_softmax_expectation.sv
// Top level of the lane grid softmax expectation block.
// Depends on lgse_pkg, lgse_ctrl and lgse_dp.
//
// Usage:
//  - in_valid/in_ready/in_logit: one signed Q8.8 logit per item. A cell is
//    num_bins location logits followed by one no-lane logit.
//  - out_valid/out_ready: one result per cell (location unsigned Q7.8, best_bin,
//    lane_present), held in an output register until taken.
//  - cfg_valid/cfg_ready/cfg_num_bins: writes num_bins (reset 100); write only
//    while idle. A write restarts the current cell.
// Timing: bin logits are taken one per cycle while the block is in its load
//  state. After the no-lane logit the block walks the N stored bins through a
//  3-stage exp/accumulate pipe, then a restoring divider gives one quotient bit
//  per cycle, then the result loads. The divider and the single store read
//  port set the cost of a cell.
// Reset: synchronous, active low; clears the cell and output valid.
//  The logit store has no reset; only bins written in the current cell are read.
// Stall: while a result waits, the next cell still loads; its finish holds
//  in the result state until the output register is free.
`timescale 1ns / 1ps
`default_nettype none
module lane_grid_softmax_expectation #(
  parameter int MAX_CHANNELS    = 128,
  parameter int EXP_TABLE_DEPTH = 256
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_valid,
  output logic                              in_ready,
  input  wire signed [lgse_pkg::LOGIT_W-1:0] in_logit,
  input  wire                               cfg_valid,
  output logic                              cfg_ready,
  input  wire        [lgse_pkg::BIN_W-1:0]  cfg_num_bins,
  output logic                              out_valid,
  input  wire                               out_ready,
  output logic       [lgse_pkg::LOC_W-1:0]  out_location,
  output logic       [lgse_pkg::BIN_W-1:0]  out_best_bin,
  output logic                              out_lane_present
);

  lgse_pkg::cmd_t    cmd;
  lgse_pkg::status_t sts;

  // config is always taken; the user writes only while idle
  assign cfg_ready = 1'b1;

  lgse_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lgse_dp #(
    .MAX_CHANNELS    (MAX_CHANNELS),
    .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_logit         (in_logit),
    .cfg_wr           (cfg_valid && cfg_ready),
    .cfg_num_bins     (cfg_num_bins),
    .cmd              (cmd),
    .sts              (sts),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_location     (out_location),
    .out_best_bin     (out_best_bin),
    .out_lane_present (out_lane_present)
  );

endmodule
`default_nettype wire
